FILE: rtl/nine_bit_link_request_engine_core_defines.svh
// Assertion macros used by the request engine back end.
`ifndef NINE_BIT_LINK_REQUEST_ENGINE_CORE_DEFINES_SVH
`define NINE_BIT_LINK_REQUEST_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define NBLRE_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define NBLRE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/nblre_pkg.sv
// Shared types and constants for the 9-bit link request engine.
package nblre_pkg;

  localparam int MAX_BLOCK_BYTES = 256;
  localparam int POS_W           = $clog2(MAX_BLOCK_BYTES + 1);
  localparam int LEN_W           = 9;
  localparam int WORD_W          = 9;
  localparam int BYTE_W          = 8;
  localparam int COUNT_W         = 25;
  localparam int CFG_DATA_W      = 25;
  localparam int CFG_INDEX_W     = 4;
  localparam int FIFO_DEPTH      = 4;
  localparam int FIFO_AW         = $clog2(FIFO_DEPTH);

  localparam logic [COUNT_W-1:0] COUNT_MAX     = {COUNT_W{1'b1}};
  localparam logic [COUNT_W-1:0] TIMEOUT_RESET = COUNT_W'(20000000);
  localparam logic [LEN_W-1:0]   LEN_CLAMP     = LEN_W'(MAX_BLOCK_BYTES);

  // Input function codes
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_RX   = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_TX    = 2'd0;
  localparam logic [1:0] KIND_STORE = 2'd1;
  localparam logic [1:0] KIND_EVENT = 2'd2;

  // Status events
  localparam logic [1:0] EV_NONE       = 2'd0;
  localparam logic [1:0] EV_BLOCK_DONE = 2'd1;
  localparam logic [1:0] EV_TIMEOUT    = 2'd2;
  localparam logic [1:0] EV_CYCLE_DONE = 2'd3;

  // Block numbers
  localparam logic [1:0] BLK_REALTIME = 2'd0;
  localparam logic [1:0] BLK_CELLS    = 2'd1;
  localparam logic [1:0] BLK_HISTORY  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_CODE_REALTIME    = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CODE_CELLS       = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CODE_HISTORY     = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CODE_ACKNOWLEDGE = 4'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_LENGTH_REALTIME  = 4'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_LENGTH_CELLS     = 4'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_LENGTH_HISTORY   = 4'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_TICKS    = 4'd7;

  typedef enum logic [1:0] {
    OP_REQUEST,
    OP_ACK_DONE,
    OP_TIMEOUT,
    OP_STORE
  } op_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  code_realtime;
    logic [BYTE_W-1:0]  code_cells;
    logic [BYTE_W-1:0]  code_history;
    logic [BYTE_W-1:0]  code_acknowledge;
    logic [LEN_W-1:0]   length_realtime;
    logic [LEN_W-1:0]   length_cells;
    logic [LEN_W-1:0]   length_history;
    logic [COUNT_W-1:0] timeout_ticks;
  } cfg_t;

  // One queued action: a transmit word or a data byte, plus its block and event
  typedef struct packed {
    op_t               op;
    logic [1:0]        block;
    logic [WORD_W-1:0] data;
    logic [BYTE_W-1:0] addr;
    logic [1:0]        ev;
  } act_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

FILE: rtl/nblre_front.sv
// Front end: accept items, track the request protocol, queue actions.
module nblre_front import nblre_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              func,
  input  logic [WORD_W-1:0] rx_word,
  input  fifo_status_t      fifo_status,
  output logic              push,
  output act_t              push_act
);

  logic [1:0]         sequence_step, sequence_step_next;
  logic               request_open, request_open_next;
  logic               reply_acknowledged, reply_acknowledged_next;
  logic               block_full, block_full_next;
  logic [POS_W-1:0]   write_position, write_position_next;
  logic [COUNT_W-1:0] wait_count, wait_count_next;

  logic               accept;
  logic [BYTE_W-1:0]  cur_code;
  logic [LEN_W-1:0]   cur_len_raw;
  logic [LEN_W-1:0]   cur_len;
  logic [COUNT_W-1:0] wait_inc;
  logic               pos_at_len;
  logic               pos_next_at_len;
  logic [POS_W-1:0]   pos_inc;

  assign in_stall = fifo_status.full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    case (sequence_step)
      BLK_REALTIME: begin
        cur_code    = cfg.code_realtime;
        cur_len_raw = cfg.length_realtime;
      end
      BLK_CELLS: begin
        cur_code    = cfg.code_cells;
        cur_len_raw = cfg.length_cells;
      end
      default: begin
        cur_code    = cfg.code_history;
        cur_len_raw = cfg.length_history;
      end
    endcase
  end

  assign cur_len         = (cur_len_raw > LEN_CLAMP) ? LEN_CLAMP : cur_len_raw;
  assign pos_inc         = write_position + POS_W'(1);
  assign pos_at_len      = LEN_W'(write_position) >= cur_len;
  assign pos_next_at_len = LEN_W'(pos_inc) >= cur_len;
  assign wait_inc        = (wait_count == COUNT_MAX) ? wait_count
                                                     : wait_count + COUNT_W'(1);

  always_comb begin
    sequence_step_next      = sequence_step;
    request_open_next       = request_open;
    reply_acknowledged_next = reply_acknowledged;
    block_full_next         = block_full;
    write_position_next     = write_position;
    wait_count_next         = wait_count;
    push                    = 1'b0;
    push_act.op             = OP_REQUEST;
    push_act.block          = sequence_step;
    push_act.data           = {1'b1, cur_code};
    push_act.addr           = write_position[BYTE_W-1:0];
    push_act.ev             = EV_NONE;

    if (accept) begin
      if (func == FUNC_TICK) begin
        if (!request_open) begin
          request_open_next       = 1'b1;
          reply_acknowledged_next = 1'b0;
          block_full_next         = 1'b0;
          write_position_next     = '0;
          wait_count_next         = '0;
          push                    = 1'b1;
        end else if (reply_acknowledged) begin
          push                    = 1'b1;
          push_act.op             = OP_ACK_DONE;
          push_act.data           = {1'b1, cfg.code_acknowledge};
          push_act.ev             = (sequence_step >= BLK_HISTORY) ? EV_CYCLE_DONE
                                                                   : EV_BLOCK_DONE;
          request_open_next       = 1'b0;
          reply_acknowledged_next = 1'b0;
          block_full_next         = 1'b1;
          wait_count_next         = '0;
          sequence_step_next      = (sequence_step >= BLK_HISTORY) ? BLK_REALTIME
                                                                   : sequence_step + 2'd1;
        end else if (wait_inc >= cfg.timeout_ticks) begin
          push              = 1'b1;
          push_act.op       = OP_TIMEOUT;
          push_act.ev       = EV_TIMEOUT;
          request_open_next = 1'b0;
          block_full_next   = 1'b1;
          wait_count_next   = '0;
        end else begin
          wait_count_next = wait_inc;
        end
      end else if (!rx_word[WORD_W-1]) begin
        wait_count_next = '0;
        if (request_open && !block_full) begin
          if (pos_at_len) begin
            block_full_next = 1'b1;
          end else begin
            push                = 1'b1;
            push_act.op         = OP_STORE;
            push_act.data       = {1'b0, rx_word[BYTE_W-1:0]};
            write_position_next = pos_inc;
            if (pos_next_at_len) begin
              block_full_next = 1'b1;
            end
          end
        end
      end else if (request_open && (rx_word[BYTE_W-1:0] == cfg.code_acknowledge)) begin
        reply_acknowledged_next = 1'b1;
        wait_count_next         = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sequence_step      <= BLK_REALTIME;
      request_open       <= 1'b0;
      reply_acknowledged <= 1'b0;
      block_full         <= 1'b1;
      write_position     <= '0;
      wait_count         <= '0;
    end else begin
      sequence_step      <= sequence_step_next;
      request_open       <= request_open_next;
      reply_acknowledged <= reply_acknowledged_next;
      block_full         <= block_full_next;
      write_position     <= write_position_next;
      wait_count         <= wait_count_next;
    end
  end

endmodule

FILE: rtl/nblre_fifo.sv
// Short action queue between the front and back ends.
module nblre_fifo import nblre_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  act_t         push_act,
  input  logic         pop,
  output act_t         head,
  output fifo_status_t status
);

  act_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;

  assign head         = mem[rd_ptr];
  assign status.full  = (count == (FIFO_AW+1)'(FIFO_DEPTH));
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_act;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (FIFO_AW+1)'(1);
        2'b01:   count <= count - (FIFO_AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/nblre_back.sv
// Back end: expand queued actions into result items behind an output register.
`include "nine_bit_link_request_engine_core_defines.svh"
module nblre_back import nblre_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  act_t              head,
  input  fifo_status_t      fifo_status,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        kind,
  output logic [WORD_W-1:0] tx_word,
  output logic [1:0]        block_select,
  output logic [BYTE_W-1:0] store_address,
  output logic [BYTE_W-1:0] store_byte,
  output logic [1:0]        event_res,
  output logic              last
);

  logic              load;
  logic              take;
  logic              phase, phase_next;
  logic [1:0]        kind_next;
  logic [WORD_W-1:0] tx_next;
  logic [BYTE_W-1:0] addr_next;
  logic [BYTE_W-1:0] byte_next;
  logic [1:0]        ev_next;
  logic              last_next;

  assign load = !out_valid || !out_stall;
  assign take = load && !fifo_status.empty;

  always_comb begin
    kind_next  = KIND_EVENT;
    tx_next    = '0;
    addr_next  = '0;
    byte_next  = '0;
    ev_next    = EV_NONE;
    last_next  = 1'b1;
    phase_next = phase;
    pop        = 1'b0;
    case (head.op)
      OP_REQUEST: begin
        kind_next = KIND_TX;
        tx_next   = head.data;
        pop       = take;
      end
      OP_ACK_DONE: begin
        // Acknowledge word first, then the completion event
        if (!phase) begin
          kind_next  = KIND_TX;
          tx_next    = head.data;
          last_next  = 1'b0;
          phase_next = take;
        end else begin
          ev_next    = head.ev;
          pop        = take;
          phase_next = !take;
        end
      end
      OP_TIMEOUT: begin
        ev_next = EV_TIMEOUT;
        pop     = take;
      end
      OP_STORE: begin
        kind_next = KIND_STORE;
        addr_next = head.addr;
        byte_next = head.data[BYTE_W-1:0];
        pop       = take;
      end
      default: begin
        pop = take;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else begin
      phase <= phase_next;
      if (load) begin
        out_valid <= !fifo_status.empty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      kind          <= kind_next;
      tx_word       <= tx_next;
      block_select  <= head.block;
      store_address <= addr_next;
      store_byte    <= byte_next;
      event_res     <= ev_next;
      last          <= last_next;
    end
  end

  `NBLRE_ASSERT_IMPLY(a_phase_on_ack, phase, !fifo_status.empty && head.op == OP_ACK_DONE, "second half of acknowledge without its action")
  `NBLRE_ASSERT_IMPLY(a_store_single, out_valid && kind == KIND_STORE, last && event_res == EV_NONE, "stored byte must be a lone result")
  `NBLRE_ASSERT_NEXT(a_ack_then_event, take && head.op == OP_ACK_DONE && !phase, out_valid && kind == KIND_TX && !last && phase, "acknowledge word not followed by pending event")

endmodule

FILE: rtl/nine_bit_link_request_engine_core.sv
// Top level of the 9-bit link request engine: config registers, front, queue, back.
//
// Master side of a 9-bit serial request link that fetches the real-time, cell
// and history blocks in turn. A poll tick with no request open transmits the
// current block's request code with bit 8 set; received data words (bit 8
// clear) come out as stored bytes with block and byte address until the
// block's length (clamped to 256) is reached; a received acknowledge command
// marks the reply, and the next tick returns the acknowledge word followed
// by a block-done or cycle-done event. Waiting ticks count toward
// timeout_ticks, after which a timeout event is reported and the block is
// requested again. The front end takes one item every clock and classifies
// it in that cycle; it stalls the input only when the four-entry action
// queue is full. The back end drains the queue through a registered output,
// one result per clock while out_stall is low, so an acknowledged tick (two
// results) occupies the output while new items keep entering. An accepted
// item passes through the action queue and then the output register before
// its first result appears. No clearing pass follows reset. Configuration
// writes are registered and are meant to be made only while no transfer is
// in flight; an index beyond the register list is ignored.
module nine_bit_link_request_engine_core import nblre_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  // configuration write port
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // input channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   func,
  input  logic [WORD_W-1:0]      rx_word,
  // result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             kind,
  output logic [WORD_W-1:0]      tx_word,
  output logic [1:0]             block_select,
  output logic [BYTE_W-1:0]      store_address,
  output logic [BYTE_W-1:0]      store_byte,
  output logic [1:0]             event_res,
  output logic                   last
);

  cfg_t         cfg;
  logic         push;
  act_t         push_act;
  logic         pop;
  act_t         head;
  fifo_status_t fifo_status;

  // Hold the configuration; each write takes the low bits it needs
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.code_realtime    <= 8'd0;
      cfg.code_cells       <= 8'd1;
      cfg.code_history     <= 8'd2;
      cfg.code_acknowledge <= 8'd3;
      cfg.length_realtime  <= LEN_W'(1);
      cfg.length_cells     <= LEN_W'(1);
      cfg.length_history   <= LEN_W'(1);
      cfg.timeout_ticks    <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CODE_REALTIME:    cfg.code_realtime    <= cfg_data[BYTE_W-1:0];
        REG_CODE_CELLS:       cfg.code_cells       <= cfg_data[BYTE_W-1:0];
        REG_CODE_HISTORY:     cfg.code_history     <= cfg_data[BYTE_W-1:0];
        REG_CODE_ACKNOWLEDGE: cfg.code_acknowledge <= cfg_data[BYTE_W-1:0];
        REG_LENGTH_REALTIME:  cfg.length_realtime  <= cfg_data[LEN_W-1:0];
        REG_LENGTH_CELLS:     cfg.length_cells     <= cfg_data[LEN_W-1:0];
        REG_LENGTH_HISTORY:   cfg.length_history   <= cfg_data[LEN_W-1:0];
        REG_TIMEOUT_TICKS:    cfg.timeout_ticks    <= cfg_data[COUNT_W-1:0];
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  // Front end: protocol state, one transfer per clock while the queue is not full
  nblre_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .rx_word     (rx_word),
    .fifo_status (fifo_status),
    .push        (push),
    .push_act    (push_act)
  );

  // Action queue decouples the two ends
  nblre_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_act (push_act),
    .pop      (pop),
    .head     (head),
    .status   (fifo_status)
  );

  // Back end: expand actions into result transfers
  nblre_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .fifo_status   (fifo_status),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .kind          (kind),
    .tx_word       (tx_word),
    .block_select  (block_select),
    .store_address (store_address),
    .store_byte    (store_byte),
    .event_res     (event_res),
    .last          (last)
  );

endmodule
